// ===== sv/kdc_pkg.sv =====
package kdc_pkg;

  typedef logic [6:0] sym_t;

  localparam int AlphaDepth = 94;

  localparam sym_t ALPHA_N      = 7'd94;
  localparam sym_t DIAL_N       = 7'd95;
  localparam sym_t FIRST_CIPHER = 7'd33;
  localparam sym_t SPACE_CODE   = 7'd32;
  localparam sym_t TILDE_CODE   = 7'd126;
  localparam sym_t NL_CODE      = 7'd10;
  localparam sym_t TAB_CODE     = 7'd9;
  // plain dial index of the tilde marker
  localparam sym_t TILDE_IDX    = 7'd94;

  typedef enum logic [2:0] {
    ST_OK    = 3'd0,
    ST_TILDE = 3'd1,
    ST_RANGE = 3'd2,
    ST_KEY   = 3'd3,
    ST_NOKEY = 3'd4
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_SWEEP
  } state_t;

  typedef struct packed {
    logic    op;
    sym_t    symbol;
    logic    end_mark;
  } item_t;

  typedef struct packed {
    sym_t    out_symbol;
    status_t status;
  } result_t;

  // write side of both tables, always written together
  typedef struct packed {
    logic en;
    sym_t alpha_addr;
    sym_t alpha_data;
    sym_t pos_addr;
    sym_t pos_data;
  } tbl_wr_t;

  // plain target index; a doubled letter becomes the tilde marker
  function automatic sym_t enc_target(input sym_t sym, input sym_t p);
    sym_t t;
    t = sym - SPACE_CODE;
    if (t == p) t = TILDE_IDX;
    return t;
  endfunction

  function automatic sym_t dial_dist(input sym_t t, input sym_t p, input sym_t n);
    logic [7:0] s;
    s = {1'b0, n} - {1'b0, p} + {1'b0, t};
    return (t > p) ? sym_t'(t - p) : s[6:0];
  endfunction

  // (a + d) mod n for a < n and d < 2n
  function automatic sym_t wrap_add(input sym_t a, input sym_t d, input sym_t n);
    sym_t       dr;
    logic [7:0] s;
    dr = (d >= n) ? sym_t'(d - n) : d;
    s  = {1'b0, a} + {1'b0, dr};
    if (s >= {1'b0, n}) s = s - {1'b0, n};
    return s[6:0];
  endfunction

endpackage

// ===== sv/kdc_in_if.sv =====
interface kdc_in_if;
  logic              valid;
  logic              ready;
  logic              op;
  kdc_pkg::sym_t     symbol;
  logic              end_mark;

  modport source (output valid, output op, output symbol, output end_mark, input ready);
  modport sink   (input valid, input op, input symbol, input end_mark, output ready);
endinterface

// ===== sv/kdc_out_if.sv =====
interface kdc_out_if;
  logic              valid;
  logic              ready;
  kdc_pkg::sym_t     out_symbol;
  kdc_pkg::status_t  status;

  modport source (output valid, output out_symbol, output status, input ready);
  modport sink   (input valid, input out_symbol, input status, output ready);
endinterface

// ===== sv/keyed_dial_cipher_stream_top.sv =====
// An accepted item is held and its table reads are registered; the result is registered
// once the output is free. No item is taken before the last is done (table read, then
// hand update and write-back). The key-end item is followed by a pass over the 94
// seen flags that fills the remaining alphabet entries; no input is taken during that pass.
// Reset (synchronous, rst_n low) clears mode, key-loaded flag, seen flags, fill count,
// hands, previous index and output valid; the alphabet tables are built by the first key after reset.
module keyed_dial_cipher_stream_top (
  input  logic       clk,
  input  logic       rst_n,
  kdc_in_if.sink     in_chan,
  kdc_out_if.source  out_chan,
  input  logic       cfg_we,
  input  logic       cfg_wdata
);

  logic              decrypt_mode_r;
  kdc_pkg::item_t    in_item;
  kdc_pkg::result_t  out_res;
  kdc_pkg::tbl_wr_t  wr;
  logic              rd_en;
  kdc_pkg::sym_t     alpha_raddr, pos_raddr, alpha_rdata, pos_rdata;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      decrypt_mode_r <= 1'b0;
    end else if (cfg_we) begin
      decrypt_mode_r <= cfg_wdata;
    end
  end

  assign in_item.op       = in_chan.op;
  assign in_item.symbol   = in_chan.symbol;
  assign in_item.end_mark = in_chan.end_mark;

  kdc_ctrl u_ctrl (
    .clk          (clk),
    .rst_n        (rst_n),
    .decrypt_mode (decrypt_mode_r),
    .in_valid     (in_chan.valid),
    .in_ready     (in_chan.ready),
    .in_item      (in_item),
    .out_valid    (out_chan.valid),
    .out_ready    (out_chan.ready),
    .out_res      (out_res),
    .wr           (wr),
    .rd_en        (rd_en),
    .alpha_raddr  (alpha_raddr),
    .pos_raddr    (pos_raddr),
    .alpha_rdata  (alpha_rdata),
    .pos_rdata    (pos_rdata)
  );

  // scrambled alphabet: cipher index -> symbol
  kdc_ram #(.Depth(kdc_pkg::AlphaDepth), .Width(7)) u_alpha_ram (
    .clk   (clk),
    .we    (wr.en),
    .waddr (wr.alpha_addr),
    .wdata (wr.alpha_data),
    .re    (rd_en),
    .raddr (alpha_raddr),
    .rdata (alpha_rdata)
  );

  // inverse table: symbol - '!' -> cipher index
  kdc_ram #(.Depth(kdc_pkg::AlphaDepth), .Width(7)) u_pos_ram (
    .clk   (clk),
    .we    (wr.en),
    .waddr (wr.pos_addr),
    .wdata (wr.pos_data),
    .re    (rd_en),
    .raddr (pos_raddr),
    .rdata (pos_rdata)
  );

  assign out_chan.out_symbol = out_res.out_symbol;
  assign out_chan.status     = out_res.status;

  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    in_chan.valid && in_chan.ready |=> !in_chan.ready)
    else $error("second transaction taken while an item is in flight");

  a_zero_on_error: assert property (@(posedge clk) disable iff (!rst_n)
    out_chan.valid && out_chan.status != kdc_pkg::ST_OK |-> out_chan.out_symbol == 7'd0)
    else $error("nonzero symbol with error status");

  a_ok_printable: assert property (@(posedge clk) disable iff (!rst_n)
    out_chan.valid && out_chan.status == kdc_pkg::ST_OK
    |-> out_chan.out_symbol != 7'd0 && out_chan.out_symbol != 7'd127)
    else $error("ok result carries an impossible symbol");

endmodule

// ===== sv/kdc_ram.sv =====
module kdc_ram #(
  parameter int Depth = 94,
  parameter int Width = 7,
  localparam int AddrW = $clog2(Depth)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AddrW-1:0] waddr,
  input  logic [Width-1:0] wdata,
  input  logic             re,
  input  logic [AddrW-1:0] raddr,
  output logic [Width-1:0] rdata
);

  logic [Width-1:0] mem [Depth];
  logic [Width-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    if (re) rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ===== sv/kdc_ctrl.sv =====
module kdc_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              decrypt_mode,
  input  logic              in_valid,
  output logic              in_ready,
  input  kdc_pkg::item_t    in_item,
  output logic              out_valid,
  input  logic              out_ready,
  output kdc_pkg::result_t  out_res,
  output kdc_pkg::tbl_wr_t  wr,
  output logic              rd_en,
  output kdc_pkg::sym_t     alpha_raddr,
  output kdc_pkg::sym_t     pos_raddr,
  input  kdc_pkg::sym_t     alpha_rdata,
  input  kdc_pkg::sym_t     pos_rdata
);

  kdc_pkg::state_t  state_r, state_nxt;
  kdc_pkg::item_t   item_r, item_nxt;
  logic             key_loaded_r, key_loaded_nxt;
  logic [kdc_pkg::AlphaDepth-1:0] seen_r, seen_nxt;
  kdc_pkg::sym_t    fill_r, fill_nxt;
  kdc_pkg::sym_t    big_r, big_nxt;
  kdc_pkg::sym_t    small_r, small_nxt;
  kdc_pkg::sym_t    prev_r, prev_nxt;
  kdc_pkg::sym_t    prev_big_r, prev_big_nxt;
  kdc_pkg::sym_t    sweep_r, sweep_nxt;
  logic             out_valid_r, out_valid_nxt;
  kdc_pkg::result_t out_res_r, out_res_nxt;

  kdc_pkg::sym_t    k_idx, enc_t, step_d, big_new, small_new, sym;
  logic             in_cipher, out_free;
  logic             text_commit, key_write, key_end;
  kdc_pkg::result_t exec_res;

  // read addresses from the incoming item, held stable state
  always_comb begin
    alpha_raddr = kdc_pkg::wrap_add(small_r,
        kdc_pkg::dial_dist(kdc_pkg::enc_target(in_item.symbol, prev_r), prev_r,
                           kdc_pkg::DIAL_N),
        kdc_pkg::ALPHA_N);
    if (in_item.symbol >= kdc_pkg::FIRST_CIPHER && in_item.symbol <= kdc_pkg::TILDE_CODE)
      pos_raddr = in_item.symbol - kdc_pkg::FIRST_CIPHER;
    else
      pos_raddr = '0;
  end

  // evaluation of the held item
  always_comb begin
    sym       = item_r.symbol;
    in_cipher = (sym >= kdc_pkg::FIRST_CIPHER) && (sym <= kdc_pkg::TILDE_CODE);
    k_idx     = sym - kdc_pkg::FIRST_CIPHER;
    enc_t     = kdc_pkg::enc_target(sym, prev_r);
    step_d    = decrypt_mode ? kdc_pkg::dial_dist(pos_rdata, prev_r, kdc_pkg::ALPHA_N)
                             : kdc_pkg::dial_dist(enc_t, prev_r, kdc_pkg::DIAL_N);
    big_new   = kdc_pkg::wrap_add(big_r, step_d, kdc_pkg::DIAL_N);
    small_new = kdc_pkg::wrap_add(small_r, step_d, kdc_pkg::ALPHA_N);

    exec_res.out_symbol = '0;
    exec_res.status     = kdc_pkg::ST_OK;
    text_commit = 1'b0;
    key_write   = 1'b0;
    key_end     = 1'b0;

    priority if (item_r.op) begin
      exec_res.status = kdc_pkg::ST_KEY;
      if (!key_loaded_r) begin
        if (in_cipher) begin
          key_write = !seen_r[k_idx] && (fill_r < kdc_pkg::ALPHA_N);
        end else if (sym != kdc_pkg::SPACE_CODE) begin
          exec_res.status = kdc_pkg::ST_RANGE;
        end
        key_end = item_r.end_mark;
      end
    end else if (!key_loaded_r) begin
      exec_res.status = kdc_pkg::ST_NOKEY;
    end else if (sym == kdc_pkg::NL_CODE || sym == kdc_pkg::TAB_CODE) begin
      exec_res.out_symbol = sym;
    end else if (!decrypt_mode) begin
      if (sym == kdc_pkg::TILDE_CODE) begin
        exec_res.status = kdc_pkg::ST_TILDE;
      end else if (sym < kdc_pkg::SPACE_CODE || sym > kdc_pkg::TILDE_CODE) begin
        exec_res.status = kdc_pkg::ST_RANGE;
      end else begin
        text_commit = 1'b1;
        exec_res.out_symbol = alpha_rdata;
      end
    end else begin
      if (!in_cipher) begin
        exec_res.status = kdc_pkg::ST_RANGE;
      end else begin
        text_commit = 1'b1;
        // landing on the tilde shows the previous big hand symbol
        exec_res.out_symbol = ((big_new == kdc_pkg::TILDE_IDX) ? prev_big_r : big_new)
                              + kdc_pkg::SPACE_CODE;
      end
    end
  end

  assign out_free = !out_valid_r || out_ready;

  always_comb begin
    state_nxt      = state_r;
    item_nxt       = item_r;
    key_loaded_nxt = key_loaded_r;
    seen_nxt       = seen_r;
    fill_nxt       = fill_r;
    big_nxt        = big_r;
    small_nxt      = small_r;
    prev_nxt       = prev_r;
    prev_big_nxt   = prev_big_r;
    sweep_nxt      = sweep_r;
    out_valid_nxt  = out_valid_r && !out_ready;
    out_res_nxt    = out_res_r;
    wr             = '0;
    rd_en          = 1'b0;
    in_ready       = 1'b0;

    unique case (state_r)
      kdc_pkg::S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          item_nxt  = in_item;
          rd_en     = 1'b1;
          state_nxt = kdc_pkg::S_EXEC;
        end
      end
      kdc_pkg::S_EXEC: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_res_nxt   = exec_res;
          if (text_commit) begin
            big_nxt   = big_new;
            small_nxt = small_new;
            if (decrypt_mode) begin
              prev_nxt     = pos_rdata;
              prev_big_nxt = big_new;
            end else begin
              prev_nxt = enc_t;
            end
          end
          if (key_write) begin
            wr.en         = 1'b1;
            wr.alpha_addr = fill_r;
            wr.alpha_data = sym;
            wr.pos_addr   = k_idx;
            wr.pos_data   = fill_r;
            seen_nxt[k_idx] = 1'b1;
            fill_nxt      = fill_r + 7'd1;
          end
          if (key_end) begin
            sweep_nxt = '0;
            state_nxt = kdc_pkg::S_SWEEP;
          end else begin
            state_nxt = kdc_pkg::S_IDLE;
          end
        end
      end
      kdc_pkg::S_SWEEP: begin
        // append unused symbols in order, inverse table written alongside
        if (!seen_r[sweep_r] && fill_r < kdc_pkg::ALPHA_N) begin
          wr.en         = 1'b1;
          wr.alpha_addr = fill_r;
          wr.alpha_data = sweep_r + kdc_pkg::FIRST_CIPHER;
          wr.pos_addr   = sweep_r;
          wr.pos_data   = fill_r;
          seen_nxt[sweep_r] = 1'b1;
          fill_nxt      = fill_r + 7'd1;
        end
        if (sweep_r == kdc_pkg::ALPHA_N - 7'd1) begin
          key_loaded_nxt = 1'b1;
          state_nxt      = kdc_pkg::S_IDLE;
        end else begin
          sweep_nxt = sweep_r + 7'd1;
        end
      end
      default: begin
        state_nxt = kdc_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= kdc_pkg::S_IDLE;
      key_loaded_r <= 1'b0;
      seen_r       <= '0;
      fill_r       <= '0;
      big_r        <= '0;
      small_r      <= '0;
      prev_r       <= '0;
      prev_big_r   <= '0;
      sweep_r      <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      key_loaded_r <= key_loaded_nxt;
      seen_r       <= seen_nxt;
      fill_r       <= fill_nxt;
      big_r        <= big_nxt;
      small_r      <= small_nxt;
      prev_r       <= prev_nxt;
      prev_big_r   <= prev_big_nxt;
      sweep_r      <= sweep_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    item_r    <= item_nxt;
    out_res_r <= out_res_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_res   = out_res_r;

endmodule
